@@ hdl/qvr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and fixed-point constants for the quaternion vector rotation core.
// No dependencies; every other file in hdl/ imports this package.
package qvr_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	// Quaternion products, matrix entries, lane products, lane sums, rounded sums.
	localparam int PROD_W  = 2 * COMP_WIDTH;
	localparam int ENTRY_W = 2 * COMP_WIDTH + 2;
	localparam int LPROD_W = ENTRY_W + COMP_WIDTH;
	localparam int ACC_W   = LPROD_W + 2;
	localparam int SHIFT   = 2 * FRAC_BITS;
	localparam int RND_W   = ACC_W - SHIFT;

	typedef logic signed [COMP_WIDTH-1:0] comp_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [ENTRY_W-1:0]    entry_t;
	typedef logic signed [LPROD_W-1:0]    lprod_t;
	typedef logic signed [RND_W-1:0]      rnd_t;

	typedef comp_t  [2:0] vec_t;
	typedef entry_t [2:0] row_t;
	typedef row_t   [2:0] mat_t;

	// Per-stage advance enables of the elastic pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

endpackage

@@ hdl/qvr_matrix.sv @@
`timescale 1ns / 1ps
// Rotation matrix builder: quaternion products (stage 1) and matrix entries (stage 2).
// Depends on qvr_pkg.
module qvr_matrix (
	input  logic          clk,
	input  qvr_pkg::adv_t adv,
	input  qvr_pkg::comp_t rot_w,
	input  qvr_pkg::comp_t rot_x,
	input  qvr_pkg::comp_t rot_y,
	input  qvr_pkg::comp_t rot_z,
	input  qvr_pkg::vec_t  vec,
	input  logic           inverse,
	output qvr_pkg::mat_t  mat_s2,
	output qvr_pkg::vec_t  vec_s2,
	output logic           inverse_s2
);
	import qvr_pkg::*;

	localparam entry_t ONE = entry_t'(1) <<< SHIFT;

	prod_t xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	vec_t  vec_s1;
	logic  inverse_s1;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			xx_s1      <= prod_t'(rot_x) * prod_t'(rot_x);
			yy_s1      <= prod_t'(rot_y) * prod_t'(rot_y);
			zz_s1      <= prod_t'(rot_z) * prod_t'(rot_z);
			xy_s1      <= prod_t'(rot_x) * prod_t'(rot_y);
			xz_s1      <= prod_t'(rot_x) * prod_t'(rot_z);
			yz_s1      <= prod_t'(rot_y) * prod_t'(rot_z);
			wx_s1      <= prod_t'(rot_w) * prod_t'(rot_x);
			wy_s1      <= prod_t'(rot_w) * prod_t'(rot_y);
			wz_s1      <= prod_t'(rot_w) * prod_t'(rot_z);
			vec_s1     <= vec;
			inverse_s1 <= inverse;
		end
	end

	// Diagonal is one minus twice a sum of squares, cross terms are twice a sum or difference.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			mat_s2[0][0] <= ONE - ((entry_t'(yy_s1) + entry_t'(zz_s1)) <<< 1);
			mat_s2[0][1] <= (entry_t'(xy_s1) - entry_t'(wz_s1)) <<< 1;
			mat_s2[0][2] <= (entry_t'(xz_s1) + entry_t'(wy_s1)) <<< 1;
			mat_s2[1][0] <= (entry_t'(xy_s1) + entry_t'(wz_s1)) <<< 1;
			mat_s2[1][1] <= ONE - ((entry_t'(xx_s1) + entry_t'(zz_s1)) <<< 1);
			mat_s2[1][2] <= (entry_t'(yz_s1) - entry_t'(wx_s1)) <<< 1;
			mat_s2[2][0] <= (entry_t'(xz_s1) - entry_t'(wy_s1)) <<< 1;
			mat_s2[2][1] <= (entry_t'(yz_s1) + entry_t'(wx_s1)) <<< 1;
			mat_s2[2][2] <= ONE - ((entry_t'(xx_s1) + entry_t'(yy_s1)) <<< 1);
			vec_s2       <= vec_s1;
			inverse_s2   <= inverse_s1;
		end
	end

endmodule

@@ hdl/qvr_lane.sv @@
`timescale 1ns / 1ps
// One output lane: row-times-vector products (stage 3), rounded sum (stage 4)
// and saturation (stage 5). Depends on qvr_pkg.
module qvr_lane (
	input  logic           clk,
	input  qvr_pkg::adv_t  adv,
	input  qvr_pkg::row_t  row,
	input  qvr_pkg::vec_t  vec,
	output qvr_pkg::comp_t out_s5,
	output logic           clip_s5
);
	import qvr_pkg::*;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (SHIFT - 1);
	localparam rnd_t SAT_HI = RND_W'({1'b0, {(COMP_WIDTH-1){1'b1}}});
	localparam rnd_t SAT_LO = -SAT_HI - RND_W'(1);

	lprod_t [2:0]              prod_s3;
	rnd_t                      rnd_s4;
	logic signed [ACC_W-1:0]   sum;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			for (int j = 0; j < 3; j++) begin
				prod_s3[j] <= lprod_t'($signed(row[j])) * lprod_t'($signed(vec[j]));
			end
		end
	end

	// Round half up: add one half, then drop the fraction bits.
	always_comb begin
		sum = ACC_W'($signed(prod_s3[0])) + ACC_W'($signed(prod_s3[1]))
			+ ACC_W'($signed(prod_s3[2])) + HALF;
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			rnd_s4 <= sum[ACC_W-1:SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			if (rnd_s4 > SAT_HI) begin
				out_s5  <= SAT_HI[COMP_WIDTH-1:0];
				clip_s5 <= 1'b1;
			end else if (rnd_s4 < SAT_LO) begin
				out_s5  <= SAT_LO[COMP_WIDTH-1:0];
				clip_s5 <= 1'b1;
			end else begin
				out_s5  <= rnd_s4[COMP_WIDTH-1:0];
				clip_s5 <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/quaternion_vector_rotate_core.sv @@
`timescale 1ns / 1ps
// Top level of the quaternion vector rotation core: elastic pipeline control,
// three output lanes and the merge into one result. Depends on qvr_pkg,
// qvr_matrix and qvr_lane.

// Each request carries a quaternion (Q1.14, one is 16384), a signed 16-bit vector and an
// inverse bit; the core builds the rotation matrix (its transpose when inverse is set),
// multiplies the vector by it with exact intermediate products, rounds each component to
// nearest with halves going up, and clips it to 16 bits, raising the saturated flag in
// tuser if any component was clipped. The quaternion is not normalized, so a non-unit
// quaternion also scales the vector. The core accepts one request every clock cycle while
// the output is not stalled. Stage 1 forms the nine quaternion products, stage 2 the
// matrix entries, and stages 3 to 5 run in three parallel lanes, one per output
// component, forming the row products, the rounded sum and the clipped value. Each stage
// only holds while its successor is full, so bubbles collapse and the input keeps taking
// requests while a finished result waits on the output, until all five stages are
// occupied. There is no state beyond the pipeline, and no configuration.
module quaternion_vector_rotate_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// rot_w[15:0], rot_x[31:16], rot_y[47:32], rot_z[63:48],
	// vec_x[79:64], vec_y[95:80], vec_z[111:96]
	input  logic [111:0] s_tdata,
	// inverse[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x[15:0], out_y[31:16], out_z[47:32]
	output logic [47:0]  m_tdata,
	// saturated[0]
	output logic         m_tuser
);
	import qvr_pkg::*;

	adv_t  adv;
	logic  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	vec_t  vec_in;
	mat_t  mat_s2;
	vec_t  vec_s2;
	logic  inverse_s2;
	mat_t  rows;
	comp_t [2:0] out_s5;
	logic  [2:0] clip_s5;

	// A stage moves on when it is empty or its successor moves on.
	always_comb begin
		adv.s5 = !valid_s5 || m_tready;
		adv.s4 = !valid_s4 || adv.s5;
		adv.s3 = !valid_s3 || adv.s4;
		adv.s2 = !valid_s2 || adv.s3;
		adv.s1 = !valid_s1 || adv.s2;
	end

	assign s_tready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv.s1) valid_s1 <= s_tvalid;
			if (adv.s2) valid_s2 <= valid_s1;
			if (adv.s3) valid_s3 <= valid_s2;
			if (adv.s4) valid_s4 <= valid_s3;
			if (adv.s5) valid_s5 <= valid_s4;
		end
	end

	assign vec_in[0] = s_tdata[79:64];
	assign vec_in[1] = s_tdata[95:80];
	assign vec_in[2] = s_tdata[111:96];

	qvr_matrix u_matrix (
		.clk        (clk),
		.adv        (adv),
		.rot_w      (s_tdata[15:0]),
		.rot_x      (s_tdata[31:16]),
		.rot_y      (s_tdata[47:32]),
		.rot_z      (s_tdata[63:48]),
		.vec        (vec_in),
		.inverse    (s_tuser),
		.mat_s2     (mat_s2),
		.vec_s2     (vec_s2),
		.inverse_s2 (inverse_s2)
	);

	// Lane i takes row i of the matrix, or column i when rotating by the inverse.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rows[i][j] = inverse_s2 ? mat_s2[j][i] : mat_s2[i][j];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		qvr_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.row     (rows[g]),
			.vec     (vec_s2),
			.out_s5  (out_s5[g]),
			.clip_s5 (clip_s5[g])
		);
	end

	// Merge: pack the three lane results and combine their clip flags.
	assign m_tvalid = valid_s5;
	assign m_tdata  = {out_s5[2], out_s5[1], out_s5[0]};
	assign m_tuser  = |clip_s5;

	// With no result waiting, every stage can move, so the input must be open.
	assert property (@(posedge clk) disable iff (!arst_n) !m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

	// An accepted request always lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted request lost at stage 1");

	// A result that is not taken keeps its data, and a full stage 4 behind it keeps its valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && valid_s5 && !m_tready |=> valid_s4 && $stable(m_tdata))
		else $error("stalled pipeline dropped or changed a result");

endmodule
